// ===== rtl/core/cdc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdc_pkg
// Shared constants for the common divisor counter: result width and the
// saturation value of the divisor count.
// ============================================================================
package cdc_pkg;

  // Width of the divisor count result
  localparam int unsigned COUNT_W = 8;

  // Largest count the result can carry; larger counts clip here
  localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

endpackage

// ===== rtl/core/cdc_in_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdc_in_if
// Valid/ready channel that carries one operand pair per transaction.
// ============================================================================
interface cdc_in_if #(
  parameter int unsigned VALUE_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] first_value;
  logic [VALUE_BITS-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

// ===== rtl/core/cdc_out_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdc_out_if
// Valid/ready channel that carries one divisor count per transaction.
// ============================================================================
interface cdc_out_if;
  import cdc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] divisor_count;

  modport source (output valid, output divisor_count, input ready);
  modport sink   (input valid, input divisor_count, output ready);
endinterface

// ===== rtl/core/cdc_cmp_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdc_cmp_unit
// Shared compare-subtract unit: reports x >= y and the difference x - y.
// Serves the gcd subtraction, the remainder step and the square bound test.
// ============================================================================
module cdc_cmp_unit #(
  parameter int unsigned WIDTH = 22
) (
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  output logic             ge_o,
  output logic [WIDTH-1:0] diff_o
);

  logic [WIDTH:0] sub;

  // One wide subtract; the borrow gives the compare
  assign sub    = {1'b0, x_i} - {1'b0, y_i};
  assign ge_o   = ~sub[WIDTH];
  assign diff_o = sub[WIDTH-1:0];

endmodule

// ===== rtl/core/common_divisor_counter_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// common_divisor_counter_top
// Counts the positive divisors common to two operands.
// ============================================================================
// Each input transaction returns one divisor count. The block forms the gcd
// with a binary (shift and subtract) algorithm, strips the factors of two,
// then trial-divides the odd part by 3, 5, 7, ... while d*d <= n, using a
// restoring remainder unit that retires one quotient bit per cycle. The gcd
// subtractions, the remainder steps and the d*d <= n test share one
// compare-subtract unit. A large odd prime gcd takes longest, as every odd d
// up to its square root is tried. One item is in work at a time; the input
// is ready again as soon as the result is handed to the output register.
// Both operands zero returns 0; counts above 255 clip at 255.
// ============================================================================
module common_divisor_counter_top #(
  parameter int unsigned VALUE_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cdc_in_if.sink      in_i,
  cdc_out_if.source   out_o
);
  import cdc_pkg::*;

  localparam int unsigned CMP_W   = VALUE_BITS + 2;
  localparam int unsigned EXP_W   = $clog2(VALUE_BITS + 1);
  localparam int unsigned STEP_W  = $clog2(VALUE_BITS);
  localparam int unsigned PROD_W  = COUNT_W + EXP_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_GCD    = 7'b0000010,
    ST_STRIP  = 7'b0000100,
    ST_TEST   = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_CHECK  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] a_q, a_d, b_q, b_d;
  logic [VALUE_BITS-1:0] n_q, n_d;
  logic [VALUE_BITS-1:0] d_q, d_d;
  logic [CMP_W-1:0]      sq_q, sq_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [EXP_W-1:0]      e_q, e_d;
  logic [COUNT_W-1:0]    total_q, total_d;
  logic                  out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]    out_count_q, out_count_d;

  logic [CMP_W-1:0]      cmp_x, cmp_y, cmp_diff;
  logic                  cmp_ge;
  logic [PROD_W-1:0]     prod;
  logic [COUNT_W-1:0]    prod_sat;
  logic [COUNT_W-1:0]    dbl_sat;
  logic                  in_acc;

  // Route the operands of the shared unit by state
  always_comb begin
    case (state_q)
      ST_GCD: begin
        cmp_x = {2'b00, a_q};
        cmp_y = {2'b00, b_q};
      end
      ST_DIV: begin
        cmp_x = {1'b0, rem_q, quo_q[VALUE_BITS-1]};
        cmp_y = {2'b00, d_q};
      end
      default: begin
        cmp_x = {2'b00, n_q};
        cmp_y = sq_q;
      end
    endcase
  end

  cdc_cmp_unit #(
    .WIDTH (CMP_W)
  ) u_cmp (
    .x_i    (cmp_x),
    .y_i    (cmp_y),
    .ge_o   (cmp_ge),
    .diff_o (cmp_diff)
  );

  // Fold (exponent + 1) into the running count, clipped
  assign prod     = {{EXP_W{1'b0}}, total_q} * {{COUNT_W{1'b0}}, e_q + EXP_W'(1)};
  assign prod_sat = (|prod[PROD_W-1:COUNT_W]) ? COUNT_SAT : prod[COUNT_W-1:0];
  assign dbl_sat  = total_q[COUNT_W-1] ? COUNT_SAT : {total_q[COUNT_W-2:0], 1'b0};

  assign in_acc        = in_i.valid && state_q[0];
  assign in_i.ready    = state_q[0];
  assign out_o.valid   = out_valid_q;
  assign out_o.divisor_count = out_count_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    n_d         = n_q;
    d_d         = d_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    e_d         = e_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_count_d = out_count_q;

    case (state_q)
      ST_IDLE: begin
        // Load a new operand pair
        if (in_acc) begin
          a_d = in_i.first_value;
          b_d = in_i.second_value;
          e_d = '0;
          if (in_i.first_value == '0 && in_i.second_value == '0) begin
            total_d = '0;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        // Binary gcd; common twos counted in e
        if (a_q == '0) begin
          n_d     = b_q;
          state_d = ST_STRIP;
        end else if (b_q == '0) begin
          n_d     = a_q;
          state_d = ST_STRIP;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          e_d = e_q + EXP_W'(1);
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (cmp_ge) begin
          a_d = cmp_diff[VALUE_BITS-1:0];
        end else begin
          a_d = b_q;
          b_d = a_q;
        end
      end
      ST_STRIP: begin
        // Remove remaining factors of two, then start trial division
        if (!n_q[0]) begin
          n_d = n_q >> 1;
          e_d = e_q + EXP_W'(1);
        end else begin
          total_d = COUNT_W'(e_q) + COUNT_W'(1);
          e_d     = '0;
          d_d     = VALUE_BITS'(3);
          sq_d    = CMP_W'(9);
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        // Continue while d*d <= n
        if (cmp_ge) begin
          rem_d   = '0;
          quo_d   = n_q;
          step_d  = '0;
          state_d = ST_DIV;
        end else begin
          if (n_q > VALUE_BITS'(1)) begin
            total_d = dbl_sat;
          end
          state_d = ST_FINISH;
        end
      end
      ST_DIV: begin
        // One restoring remainder step per cycle
        rem_d  = cmp_ge ? cmp_diff[VALUE_BITS-1:0] : cmp_x[VALUE_BITS-1:0];
        quo_d  = {quo_q[VALUE_BITS-2:0], cmp_ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(VALUE_BITS - 1)) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (rem_q == '0) begin
          // d divides n: take the quotient and divide again
          n_d     = quo_q;
          e_d     = e_q + EXP_W'(1);
          quo_d   = quo_q;
          step_d  = '0;
          state_d = ST_DIV;
        end else begin
          // Close this divisor and advance to the next odd one
          total_d = prod_sat;
          e_d     = '0;
          d_d     = d_q + VALUE_BITS'(2);
          sq_d    = sq_q + {d_q, 2'b00} + CMP_W'(4);
          state_d = ST_TEST;
        end
      end
      ST_FINISH: begin
        // Hand over once the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_count_d = total_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    b_q         <= b_d;
    n_q         <= n_d;
    d_q         <= d_d;
    sq_q        <= sq_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    step_q      <= step_d;
    e_q         <= e_d;
    total_q     <= total_d;
    out_count_q <= out_count_d;
  end

endmodule

// ===== rtl/core/cdc_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdc_checker
// Port-level checks for the common divisor counter, bound to the top level.
// ============================================================================
module cdc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [cdc_pkg::COUNT_W-1:0] divisor_count_i
);
  import cdc_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending_q, pending_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Track transactions taken in but not yet delivered
  always_comb begin
    pending_d = pending_q;
    if (in_acc && !out_acc) begin
      pending_d = pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(divisor_count_i))
    else $error("result changed while stalled");

  // One item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input taken while an item is in work");

  // Every result answers an accepted item; at most two in flight
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || pending_q != 2'd0) && pending_q != 2'd3)
    else $error("result without a matching input");

endmodule

bind common_divisor_counter_top cdc_checker u_cdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .divisor_count_i (out_o.divisor_count)
);
